/* rtl/us2utc_pkg.sv */
// Constants for the seconds-to-UTC-date converter: calendar figures and
// reciprocal multipliers used for division by constants.
// No dependencies.
package us2utc_pkg;

    // Calendar figures
    localparam int C_MAR1BC_DAYS  = 719527;  // days from March 1 of 1 BC to the epoch (+59)
    localparam int C_JAN_FEB_DAYS = 59;
    localparam int C_DAYS_400Y    = 146097;  // days in 400 Gregorian years
    localparam int C_DAY_DIV      = 675;     // 86400 / 128
    localparam int C_HOUR_DIV     = 225;     // 3600 / 16
    localparam int C_MIN_DIV      = 15;      // 60 / 4
    localparam int C_WEEK_DAYS    = 7;
    localparam int C_CENT_DIV     = 25;      // 100 / 4 and 400 / 16
    localparam int C_MON_SPAN     = 306;
    localparam int C_THIRD_DIV    = 3;       // 12 / 4

    localparam logic [31:0] C_SECS_PER_DAY  = 32'd86400;
    localparam logic [16:0] C_SECS_PER_HOUR = 17'd3600;
    localparam logic [11:0] C_SECS_PER_MIN  = 12'd60;
    localparam logic [15:0] C_EPOCH_WDAY    = 16'd4;     // 1970-01-01 was a Thursday
    localparam logic [19:0] C_DP_OFFSET     = 20'(C_MAR1BC_DAYS - C_JAN_FEB_DAYS + 2);
    localparam logic [28:0] C_YEAR_SCALE    = 29'd400;
    localparam logic [19:0] C_DAYS_PER_YEAR = 20'd365;
    localparam logic [8:0]  C_MARCH_YDAYS   = 9'd306;    // March-based day where January starts
    localparam logic [12:0] C_MON_STEP      = 13'd367;

    // Reciprocal shifts, each chosen so the truncated product is exact
    // over the full operand range.
    localparam int C_DAY_SH   = 35;
    localparam int C_HOUR_SH  = 21;
    localparam int C_MIN_SH   = 14;
    localparam int C_WDAY_SH  = 19;
    localparam int C_YEAR_SH  = 47;
    localparam int C_CENT_SH  = 15;
    localparam int C_MON_SH   = 21;
    localparam int C_THIRD_SH = 13;

    localparam logic [25:0] C_DAY_RCP  =
        26'(((64'd1 << C_DAY_SH) + 64'(C_DAY_DIV) - 64'd1) / 64'(C_DAY_DIV));
    localparam logic [13:0] C_HOUR_RCP =
        14'(((64'd1 << C_HOUR_SH) + 64'(C_HOUR_DIV) - 64'd1) / 64'(C_HOUR_DIV));
    localparam logic [10:0] C_MIN_RCP  =
        11'(((64'd1 << C_MIN_SH) + 64'(C_MIN_DIV) - 64'd1) / 64'(C_MIN_DIV));
    localparam logic [16:0] C_WDAY_RCP =
        17'(((64'd1 << C_WDAY_SH) + 64'(C_WEEK_DAYS) - 64'd1) / 64'(C_WEEK_DAYS));
    localparam logic [29:0] C_YEAR_RCP =
        30'(((64'd1 << C_YEAR_SH) + 64'(C_DAYS_400Y) - 64'd1) / 64'(C_DAYS_400Y));
    localparam logic [10:0] C_CENT_RCP =
        11'(((64'd1 << C_CENT_SH) + 64'(C_CENT_DIV) - 64'd1) / 64'(C_CENT_DIV));
    localparam logic [12:0] C_MON_RCP  =
        13'(((64'd1 << C_MON_SH) + 64'(C_MON_SPAN) - 64'd1) / 64'(C_MON_SPAN));
    localparam logic [11:0] C_THIRD_RCP =
        12'(((64'd1 << C_THIRD_SH) + 64'(C_THIRD_DIV) - 64'd1) / 64'(C_THIRD_DIV));

endpackage

/* rtl/unix_seconds_to_utc_date.sv */
// Throughput: one transaction per cycle while i_ready is high; stages S1 to S15
// each hold one item, and the result sits on the S15 output registers.
// Stalls: a stage moves when it is empty or the stage after it moves, so
// bubbles close up and the input stays ready while the output waits, until
// all 15 stages hold an item.
// Reset (i_rst_n, synchronous, active low) clears only the stage valid bits.
// Depends on us2utc_pkg.
module unix_seconds_to_utc_date
    import us2utc_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [31:0] i_unix_seconds,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [5:0]  o_second,
    output logic [5:0]  o_minute,
    output logic [4:0]  o_hour,
    output logic [4:0]  o_day_of_month,
    output logic [3:0]  o_month,
    output logic [11:0] o_year,
    output logic [2:0]  o_weekday
);

    localparam int C_NS = 15;

    // ------------------------------------------------------------------
    // Stage flow control: valid bits ride with the data; each stage
    // advances when empty or when its successor advances.
    // ------------------------------------------------------------------
    logic [C_NS:1] r_vld;
    logic [C_NS:1] adv;

    always_comb begin
        adv[C_NS] = !r_vld[C_NS] || i_ready;
        for (int k = C_NS - 1; k >= 1; k--) begin
            adv[k] = !r_vld[k] || adv[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (adv[1]) begin
                r_vld[1] <= i_valid;
            end
            for (int k = 2; k <= C_NS; k++) begin
                if (adv[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    assign o_ready = adv[1];
    assign o_valid = r_vld[C_NS];

    // ------------------------------------------------------------------
    // Datapath registers, named by stage
    // ------------------------------------------------------------------
    // S1: seconds / 86400 as (n >> 7) * reciprocal
    logic [50:0] r_s1_prod;
    logic [31:0] r_s1_n;
    // S2: day count and its seconds
    logic [15:0] r_s2_days;
    logic [31:0] r_s2_dayx;
    logic [31:0] r_s2_n;
    // S3: second of day, shifted day count, weekday operand
    logic [16:0] r_s3_rem;
    logic [19:0] r_s3_dp;
    logic [15:0] r_s3_w4;
    // S4: year numerator, hour and weekday products
    logic [28:0] r_s4_ynum;
    logic [26:0] r_s4_hp;
    logic [32:0] r_s4_wp;
    logic [16:0] r_s4_rem;
    logic [15:0] r_s4_w4;
    logic [19:0] r_s4_dp;
    // S5: year estimate product, hour, weekday quotient back-product
    logic [58:0] r_s5_yp;
    logic [4:0]  r_s5_hour;
    logic [16:0] r_s5_hx;
    logic [15:0] r_s5_wx;
    logic [16:0] r_s5_rem;
    logic [15:0] r_s5_w4;
    logic [19:0] r_s5_dp;
    // S6: estimated year, second of hour, weekday
    logic [11:0] r_s6_year0;
    logic [11:0] r_s6_r2;
    logic [2:0]  r_s6_wday;
    logic [4:0]  r_s6_hour;
    logic [19:0] r_s6_dp;
    // S7: products for the year start and the minute
    logic [19:0] r_s7_y365;
    logic [20:0] r_s7_q100p;
    logic [18:0] r_s7_q400p;
    logic [20:0] r_s7_minp;
    logic [11:0] r_s7_r2;
    logic [4:0]  r_s7_hour;
    logic [2:0]  r_s7_wday;
    logic [19:0] r_s7_dp;
    logic [11:0] r_s7_year0;
    // S8: day number of the estimated year start, leap flag, minute
    logic [19:0] r_s8_base;
    logic        r_s8_leap;
    logic [5:0]  r_s8_min;
    logic [11:0] r_s8_secx;
    logic [11:0] r_s8_r2;
    logic [4:0]  r_s8_hour;
    logic [2:0]  r_s8_wday;
    logic [19:0] r_s8_dp;
    logic [11:0] r_s8_year0;
    // S9: signed day of year, second
    logic signed [21:0] r_s9_yday;
    logic [5:0]  r_s9_sec;
    logic [5:0]  r_s9_min;
    logic [4:0]  r_s9_hour;
    logic [2:0]  r_s9_wday;
    logic [11:0] r_s9_year0;
    logic        r_s9_leap;
    // S10..S14: month estimate and day-of-month product
    logic [8:0]  r_s10_yday;
    logic [11:0] r_s11_mx;
    logic [24:0] r_s12_mp;
    logic [3:0]  r_s13_mon;
    logic [12:0] r_s13_p367;
    logic [22:0] r_s14_qp;
    logic [3:0]  r_s14_mon;
    // carried through S10..S14
    logic [8:0]  r_yday   [10:14];
    logic [11:0] r_year   [10:14];
    logic        r_jf     [10:14];
    logic [5:0]  r_sec    [10:14];
    logic [5:0]  r_min    [10:14];
    logic [4:0]  r_hour   [10:14];
    logic [2:0]  r_wday   [10:14];
    // S15: output registers
    logic [5:0]  r_s15_sec;
    logic [5:0]  r_s15_min;
    logic [4:0]  r_s15_hour;
    logic [4:0]  r_s15_mday;
    logic [3:0]  r_s15_mon;
    logic [11:0] r_s15_year;
    logic [2:0]  r_s15_wday;

    // ------------------------------------------------------------------
    // Stage logic between registers
    // ------------------------------------------------------------------
    logic [15:0] s2_days;
    logic [4:0]  s5_hour;
    logic [13:0] s5_wq;
    logic [5:0]  s8_q100;
    logic [3:0]  s8_q400;
    logic [5:0]  s8_min;
    logic        s8_div100;
    logic        s8_div400;
    logic        s8_leap;
    logic [19:0] s8_base;
    logic [21:0] s9_yday;
    logic [8:0]  s10_yday;
    logic [11:0] s10_year;
    logic [3:0]  s13_mon;
    logic [9:0]  s15_q;
    logic [9:0]  s15_mday;

    assign s2_days = r_s1_prod[C_DAY_SH +: 16];
    assign s5_hour = r_s4_hp[C_HOUR_SH +: 5];
    assign s5_wq   = r_s4_wp[C_WDAY_SH +: 14];

    // Year start: 365*y + y/4 - y/100 + y/400; y/100 = (y>>2)/25, y/400 = (y>>4)/25
    assign s8_q100   = r_s7_q100p[C_CENT_SH +: 6];
    assign s8_q400   = r_s7_q400p[C_CENT_SH +: 4];
    assign s8_min    = r_s7_minp[C_MIN_SH +: 6];
    assign s8_div100 = (10'(s8_q100) * 10'(C_CENT_DIV)) == r_s7_year0[11:2];
    assign s8_div400 = (r_s7_year0[3:0] == 4'd0)
                    && ((8'(s8_q400) * 8'(C_CENT_DIV)) == r_s7_year0[11:4]);
    assign s8_leap   = (r_s7_year0[1:0] == 2'd0) && (!s8_div100 || s8_div400);
    assign s8_base   = r_s7_y365 + 20'(r_s7_year0[11:2]) - 20'(s8_q100)
                     + 20'(s8_q400);

    // r_s8_dp carries the +2 of the year estimate; take it back off here
    assign s9_yday = 22'(r_s8_dp) - 22'd2 - 22'(r_s8_base);

    // Year estimate ran past March 1: borrow the previous March-based year
    always_comb begin
        if (r_s9_yday[21]) begin
            s10_yday = r_s9_yday[8:0] + 9'(C_DAYS_PER_YEAR) + 9'(r_s9_leap);
            s10_year = r_s9_year0 - 12'd1;
        end else begin
            s10_yday = r_s9_yday[8:0];
            s10_year = r_s9_year0;
        end
    end

    assign s13_mon = r_s12_mp[C_MON_SH +: 4];

    // mday = yday - (367*mon/12 - 30) + 1
    assign s15_q    = r_s14_qp[C_THIRD_SH +: 10];
    assign s15_mday = 10'(r_yday[14]) - s15_q + 10'd31;

    always_ff @(posedge i_clk) begin
        if (adv[1]) begin
            r_s1_prod <= 51'(i_unix_seconds[31:7]) * 51'(C_DAY_RCP);
            r_s1_n    <= i_unix_seconds;
        end
        if (adv[2]) begin
            r_s2_days <= s2_days;
            r_s2_dayx <= 32'(s2_days) * C_SECS_PER_DAY;
            r_s2_n    <= r_s1_n;
        end
        if (adv[3]) begin
            r_s3_rem <= 17'(r_s2_n - r_s2_dayx);
            r_s3_dp  <= 20'(r_s2_days) + C_DP_OFFSET;
            r_s3_w4  <= r_s2_days + C_EPOCH_WDAY;
        end
        if (adv[4]) begin
            r_s4_ynum <= 29'(r_s3_dp) * C_YEAR_SCALE;
            r_s4_hp   <= 27'(r_s3_rem[16:4]) * 27'(C_HOUR_RCP);
            r_s4_wp   <= 33'(r_s3_w4) * 33'(C_WDAY_RCP);
            r_s4_rem  <= r_s3_rem;
            r_s4_w4   <= r_s3_w4;
            r_s4_dp   <= r_s3_dp;
        end
        if (adv[5]) begin
            r_s5_yp   <= 59'(r_s4_ynum) * 59'(C_YEAR_RCP);
            r_s5_hour <= s5_hour;
            r_s5_hx   <= 17'(s5_hour) * C_SECS_PER_HOUR;
            r_s5_wx   <= 16'(s5_wq) * 16'(C_WEEK_DAYS);
            r_s5_rem  <= r_s4_rem;
            r_s5_w4   <= r_s4_w4;
            r_s5_dp   <= r_s4_dp;
        end
        if (adv[6]) begin
            r_s6_year0 <= r_s5_yp[C_YEAR_SH +: 12];
            r_s6_r2    <= 12'(r_s5_rem - r_s5_hx);
            r_s6_wday  <= 3'(r_s5_w4 - r_s5_wx);
            r_s6_hour  <= r_s5_hour;
            r_s6_dp    <= r_s5_dp;
        end
        if (adv[7]) begin
            r_s7_y365  <= 20'(r_s6_year0) * C_DAYS_PER_YEAR;
            r_s7_q100p <= 21'(r_s6_year0[11:2]) * 21'(C_CENT_RCP);
            r_s7_q400p <= 19'(r_s6_year0[11:4]) * 19'(C_CENT_RCP);
            r_s7_minp  <= 21'(r_s6_r2[11:2]) * 21'(C_MIN_RCP);
            r_s7_r2    <= r_s6_r2;
            r_s7_hour  <= r_s6_hour;
            r_s7_wday  <= r_s6_wday;
            r_s7_dp    <= r_s6_dp;
            r_s7_year0 <= r_s6_year0;
        end
        if (adv[8]) begin
            r_s8_base  <= s8_base;
            r_s8_leap  <= s8_leap;
            r_s8_min   <= s8_min;
            r_s8_secx  <= 12'(s8_min) * C_SECS_PER_MIN;
            r_s8_r2    <= r_s7_r2;
            r_s8_hour  <= r_s7_hour;
            r_s8_wday  <= r_s7_wday;
            r_s8_dp    <= r_s7_dp;
            r_s8_year0 <= r_s7_year0;
        end
        if (adv[9]) begin
            r_s9_yday  <= s9_yday;
            r_s9_sec   <= 6'(r_s8_r2 - r_s8_secx);
            r_s9_min   <= r_s8_min;
            r_s9_hour  <= r_s8_hour;
            r_s9_wday  <= r_s8_wday;
            r_s9_year0 <= r_s8_year0;
            r_s9_leap  <= r_s8_leap;
        end
        if (adv[10]) begin
            r_s10_yday  <= s10_yday;
            r_yday[10]  <= s10_yday;
            r_year[10]  <= s10_year;
            r_jf[10]    <= s10_yday >= C_MARCH_YDAYS;
            r_sec[10]   <= r_s9_sec;
            r_min[10]   <= r_s9_min;
            r_hour[10]  <= r_s9_hour;
            r_wday[10]  <= r_s9_wday;
        end
        if (adv[11]) begin
            r_s11_mx <= (12'(r_s10_yday) + 12'd31) * 12'd10;
        end
        if (adv[12]) begin
            r_s12_mp <= 25'(r_s11_mx) * 25'(C_MON_RCP);
        end
        if (adv[13]) begin
            r_s13_mon  <= s13_mon;
            r_s13_p367 <= 13'(s13_mon) * C_MON_STEP;
        end
        if (adv[14]) begin
            r_s14_qp  <= 23'(r_s13_p367[12:2]) * 23'(C_THIRD_RCP);
            r_s14_mon <= r_s13_mon;
        end
        for (int k = 11; k <= 14; k++) begin
            if (adv[k]) begin
                r_yday[k] <= r_yday[k-1];
                r_year[k] <= r_year[k-1];
                r_jf[k]   <= r_jf[k-1];
                r_sec[k]  <= r_sec[k-1];
                r_min[k]  <= r_min[k-1];
                r_hour[k] <= r_hour[k-1];
                r_wday[k] <= r_wday[k-1];
            end
        end
        // January and February belong to the next calendar year
        if (adv[15]) begin
            r_s15_sec  <= r_sec[14];
            r_s15_min  <= r_min[14];
            r_s15_hour <= r_hour[14];
            r_s15_wday <= r_wday[14];
            r_s15_mday <= s15_mday[4:0];
            r_s15_mon  <= r_jf[14] ? (r_s14_mon - 4'd10) : (r_s14_mon + 4'd2);
            r_s15_year <= r_jf[14] ? (r_year[14] + 12'd1) : r_year[14];
        end
    end

    assign o_second       = r_s15_sec;
    assign o_minute       = r_s15_min;
    assign o_hour         = r_s15_hour;
    assign o_day_of_month = r_s15_mday;
    assign o_month        = r_s15_mon;
    assign o_year         = r_s15_year;
    assign o_weekday      = r_s15_wday;

endmodule
